>>> rtl/thruster_mix_to_pwm_core_defines.svh
// Assertion macros used by the checker file.
`ifndef THRUSTER_MIX_TO_PWM_CORE_DEFINES_SVH
`define THRUSTER_MIX_TO_PWM_CORE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define TMP_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset
`define TMP_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/thr_mix_pkg.sv
`default_nettype none

package thr_mix_pkg;

    // Fixed geometry
    localparam int AXIS_COUNT      = 6;
    localparam int MOTOR_COUNT_DEF = 6;

    // Datapath widths
    localparam int DATA_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int ACC_W      = 34;   // six Q.29 products, exact
    localparam int X_W        = 31;   // clamped sum, [-2^29, 2^29]
    localparam int OPB_W      = 17;
    localparam int PROD_W     = X_W + OPB_W;
    localparam int FRAC_BITS  = 29;

    localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1) <<< FRAC_BITS;

    // Pulse constants in microseconds
    localparam logic [15:0] IDLE_ONE_WAY   = 16'd1000;
    localparam logic [15:0] IDLE_TWO_WAY   = 16'd1500;
    localparam logic [15:0] CENTRE_TWO_WAY = 16'd1500;

    // Register reset values
    localparam logic        RST_ESC_MODE     = 1'b0;
    localparam logic [14:0] RST_YAW_DEADZONE = 15'd0;
    localparam logic [15:0] RST_PULSE_BASE   = 16'd1000;
    localparam logic [15:0] RST_PULSE_SPAN   = 16'd1000;

    // Configuration register index
    typedef enum logic [1:0] {
        CFG_ESC_MODE     = 2'd0,
        CFG_YAW_DEADZONE = 2'd1,
        CFG_PULSE_BASE   = 2'd2,
        CFG_PULSE_SPAN   = 2'd3
    } t_cfg_idx;

    // Request kind
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_MIX  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic        [2:0]  motor_index;
        logic        [2:0]  axis_index;
        logic signed [15:0] factor_value;
        logic signed [15:0] roll_demand;
        logic signed [15:0] pitch_demand;
        logic signed [15:0] yaw_demand;
        logic signed [15:0] throttle_demand;
        logic signed [15:0] forward_demand;
        logic signed [15:0] lateral_demand;
        logic               armed;
        logic               stabilize_mode;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  motor_number;
        logic [15:0] pulse_width;
        logic        last_motor;
    } t_out_res;

endpackage

`default_nettype wire

>>> rtl/thruster_mix_to_pwm_core.sv
// Six-axis thruster mixer with PWM pulse-width output.
// Input channel (i_in_valid / o_in_stall, i_in_req): a load request writes
// one factor of the motor x axis table and does not stall the input; a mix request
// produces MOTOR_COUNT results, motors in ascending order, last_motor set on
// the final one. Output channel (o_out_valid / i_out_stall, o_out_res) is
// held in an output register and stays stable while stalled.
// Armed mix, per motor: six multiply-accumulates through the one shared
// 31x17 multiplier fed by the single read port of the factor memory, a
// drain of the MAC pipeline, a clamp and one more pass through the same
// multiplier for the pulse scaling. Disarmed mix: one result per cycle
// while the output is not stalled.
// o_in_stall is high from an accepted mix until its last result has been
// placed in the output register. A stalled receiver holds the sequencer in
// its emit step, so no result is dropped.
// Reset (synchronous, i_rst_n low): sequencer idle, output empty, all
// factors read as zero, registers at one-way ESC mode, yaw deadzone 0,
// pulse base 1000, pulse span 1000. Config writes are taken any cycle
// and must only be issued while the block is idle.
`default_nettype none

module thruster_mix_to_pwm_core #(
    parameter int MOTOR_COUNT = thr_mix_pkg::MOTOR_COUNT_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire thr_mix_pkg::t_in_req                 i_in_req,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output thr_mix_pkg::t_out_res                     o_out_res,
    input  wire logic                                 i_cfg_we,
    input  wire thr_mix_pkg::t_cfg_idx                i_cfg_idx,
    input  wire logic [thr_mix_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import thr_mix_pkg::*;

    localparam int DEPTH = MOTOR_COUNT * AXIS_COUNT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_CLAMP,
        S_SCALE,
        S_EMIT
    } t_state;

    t_state                    r_state;
    logic                      r_esc;
    logic        [14:0]        r_dz;
    logic        [15:0]        r_tmin;
    logic        [15:0]        r_trange;
    logic signed [15:0]        r_dem [AXIS_COUNT];
    logic signed [15:0]        r_dem_q;
    logic                      r_armed;
    logic        [2:0]         r_mot;
    logic        [2:0]         r_ax;
    logic        [AW-1:0]      r_addr;
    logic                      r_p1;
    logic                      r_p2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [X_W-1:0]     r_x;
    logic                      r_out_valid;
    t_out_res                  r_out_res;

    logic                      w_accept;
    logic                      w_we;
    logic        [5:0]         w_waddr_full;
    logic signed [15:0]        w_factor;
    logic signed [15:0]        w_yaw;
    logic signed [16:0]        w_yaw_ext;
    logic        [16:0]        w_yaw_mag;
    logic                      w_dz_hit;
    logic signed [15:0]        w_dz_pos;
    logic signed [15:0]        w_yaw_adj;
    logic signed [X_W-1:0]     w_mul_a;
    logic signed [OPB_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0]  w_mul;
    logic signed [PROD_W-1:0]  w_base;
    logic signed [PROD_W-1:0]  w_num;
    logic signed [PROD_W-1:0]  w_q;
    logic        [15:0]        n_pw;
    logic                      w_out_free;
    logic                      w_last;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last     = (r_mot == 3'(MOTOR_COUNT - 1));

    // Load address and range check
    assign w_waddr_full = 6'(i_in_req.motor_index) * 6'(AXIS_COUNT)
                        + 6'(i_in_req.axis_index);
    assign w_we = w_accept && (i_in_req.kind == KIND_LOAD)
               && ({1'b0, i_in_req.motor_index} < 4'(MOTOR_COUNT))
               && (i_in_req.axis_index < 3'(AXIS_COUNT));

    thr_mix_fmem #(
        .DEPTH (DEPTH)
    ) u_fmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr_full[AW-1:0]),
        .i_wdata (i_in_req.factor_value),
        .i_re    (r_state == S_MAC),
        .i_raddr (r_addr),
        .o_rdata (w_factor)
    );

    // Yaw deadzone in stabilize mode with no forward demand; zero goes to plus
    assign w_yaw     = i_in_req.yaw_demand;
    assign w_yaw_ext = {w_yaw[15], w_yaw};
    assign w_yaw_mag = w_yaw[15] ? 17'(-w_yaw_ext) : 17'(w_yaw_ext);
    assign w_dz_hit  = i_in_req.stabilize_mode && (i_in_req.forward_demand == 16'sd0)
                    && (w_yaw_mag < {2'b00, r_dz});
    assign w_dz_pos  = $signed({1'b0, r_dz});
    assign w_yaw_adj = !w_dz_hit ? w_yaw : (w_yaw[15] ? -w_dz_pos : w_dz_pos);

    // Shared multiplier: demand x factor, or clamped sum x pulse span
    always_comb begin
        if (r_state == S_SCALE) begin
            w_mul_a = r_x;
            w_mul_b = $signed({1'b0, r_trange});
        end else begin
            w_mul_a = {{(X_W - 16){r_dem_q[15]}}, r_dem_q};
            w_mul_b = {w_factor[15], w_factor};
        end
    end
    assign w_mul = w_mul_a * w_mul_b;

    // Pulse scaling and saturation, idle pulse when disarmed
    assign w_base = r_esc ? (PROD_W'(CENTRE_TWO_WAY) << (FRAC_BITS + 1))
                          : (PROD_W'(r_tmin) << FRAC_BITS);
    assign w_num  = w_base + r_prod;
    assign w_q    = r_esc ? (w_num >>> (FRAC_BITS + 1)) : (w_num >>> FRAC_BITS);

    always_comb begin
        if (!r_armed) begin
            n_pw = r_esc ? IDLE_TWO_WAY : IDLE_ONE_WAY;
        end else if (w_num[PROD_W-1]) begin
            n_pw = 16'd0;
        end else if (|w_q[PROD_W-1:16]) begin
            n_pw = 16'hFFFF;
        end else begin
            n_pw = w_q[15:0];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc    <= RST_ESC_MODE;
            r_dz     <= RST_YAW_DEADZONE;
            r_tmin   <= RST_PULSE_BASE;
            r_trange <= RST_PULSE_SPAN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ESC_MODE:     r_esc    <= i_cfg_data[0];
                CFG_YAW_DEADZONE: r_dz     <= i_cfg_data[14:0];
                CFG_PULSE_BASE:   r_tmin   <= i_cfg_data[15:0];
                CFG_PULSE_SPAN:   r_trange <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer, MAC pipeline and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_armed     <= 1'b0;
            r_mot       <= '0;
            r_ax        <= '0;
        end else begin
            // read -> multiply -> accumulate
            r_p1 <= (r_state == S_MAC);
            r_p2 <= r_p1;
            if (r_p1 || (r_state == S_SCALE)) begin
                r_prod <= w_mul;
            end
            if (r_p2) begin
                r_acc <= r_acc + $signed(r_prod[ACC_W-1:0]);
            end

            if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_in_req.kind == KIND_MIX)) begin
                        r_dem[0] <= i_in_req.roll_demand;
                        r_dem[1] <= i_in_req.pitch_demand;
                        r_dem[2] <= w_yaw_adj;
                        r_dem[3] <= i_in_req.throttle_demand;
                        r_dem[4] <= i_in_req.forward_demand;
                        r_dem[5] <= i_in_req.lateral_demand;
                        r_armed  <= i_in_req.armed;
                        r_mot    <= '0;
                        r_ax     <= '0;
                        r_addr   <= '0;
                        r_acc    <= '0;
                        r_state  <= i_in_req.armed ? S_MAC : S_EMIT;
                    end
                end
                S_MAC: begin
                    // issue one factor read per cycle
                    r_dem_q <= r_dem[r_ax];
                    r_addr  <= r_addr + AW'(1);
                    if (r_ax == 3'(AXIS_COUNT - 1)) begin
                        r_ax    <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_ax <= r_ax + 3'd1;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1 && !r_p2) begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    if (r_acc > ACC_ONE) begin
                        r_x <= X_W'(ACC_ONE);
                    end else if (r_acc < -ACC_ONE) begin
                        r_x <= X_W'(-ACC_ONE);
                    end else begin
                        r_x <= r_acc[X_W-1:0];
                    end
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out_res.motor_number <= r_mot;
                        r_out_res.pulse_width  <= n_pw;
                        r_out_res.last_motor   <= w_last;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_mot   <= r_mot + 3'd1;
                            r_acc   <= '0;
                            r_state <= r_armed ? S_MAC : S_EMIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule

`default_nettype wire

>>> rtl/thr_mix_fmem.sv
`default_nettype none

// Factor table: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
module thr_mix_fmem #(
    parameter int DEPTH = thr_mix_pkg::MOTOR_COUNT_DEF * thr_mix_pkg::AXIS_COUNT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_we,
    input  wire logic [$clog2(DEPTH)-1:0]             i_waddr,
    input  wire logic [thr_mix_pkg::DATA_W-1:0]       i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [$clog2(DEPTH)-1:0]             i_raddr,
    output logic      [thr_mix_pkg::DATA_W-1:0]       o_rdata
);
    import thr_mix_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [DATA_W-1:0] r_rdata;
    logic              r_rvld;

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
            r_rvld  <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

>>> rtl/thr_mix_chk.sv
`default_nettype none

`include "thruster_mix_to_pwm_core_defines.svh"

// Port-level checks on the thruster mixer
module thr_mix_chk #(
    parameter int MOTOR_COUNT = thr_mix_pkg::MOTOR_COUNT_DEF
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire thr_mix_pkg::t_in_req  i_in_req,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire thr_mix_pkg::t_out_res o_out_res
);
    import thr_mix_pkg::*;

    // stalled result holds
    `TMP_CHK_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_res), "result changed while stalled")

    // an accepted mix request makes the block stall the input
    `TMP_CHK_NEXT(a_mix_busy, i_in_valid && !o_in_stall && (i_in_req.kind == KIND_MIX), o_in_stall, "mix request did not occupy the block")

    // a load request does not stall the input
    `TMP_CHK_NEXT(a_load_quick, i_in_valid && !o_in_stall && (i_in_req.kind == KIND_LOAD), !o_in_stall, "load request stalled the input")

    // last_motor flags exactly the highest motor number
    `TMP_CHK_NOW(a_last_flag, o_out_valid, o_out_res.last_motor == (o_out_res.motor_number == 3'(MOTOR_COUNT - 1)), "last_motor flag mismatch")

endmodule

bind thruster_mix_to_pwm_core thr_mix_chk #(
    .MOTOR_COUNT (MOTOR_COUNT)
) u_thr_mix_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res)
);

`default_nettype wire
